[rtl/core/sidc_pkg.sv]
package sidc_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int DIG_W      = 4;
  localparam int NUM_DIGITS = 10;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int REM_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  // one command shared by every cell of the digit chain
  typedef struct packed {
    logic clr;  // zero the digit
    logic dab;  // add-3 correction, then shift one bit in from below
    logic dsh;  // take the digit of the cell below
  } cell_ctrl_t;

endpackage

[rtl/core/sidc_bcd_cell.sv]
module sidc_bcd_cell
  import sidc_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic             bit_in,
  output logic             bit_out,
  input  logic [DIG_W-1:0] dig_in,
  output logic [DIG_W-1:0] dig_out
);

  logic [DIG_W-1:0] digit;
  logic [DIG_W-1:0] digit_next;
  logic [DIG_W-1:0] adj;

  // correct by three so the shift carries past nine
  assign adj     = (digit >= DIG_W'(5)) ? digit + DIG_W'(3) : digit;
  assign bit_out = adj[DIG_W-1];
  assign dig_out = digit;

  always_comb begin
    priority if (ctrl.clr) begin
      digit_next = '0;
    end else if (ctrl.dab) begin
      digit_next = {adj[DIG_W-2:0], bit_in};
    end else if (ctrl.dsh) begin
      digit_next = dig_in;
    end else begin
      digit_next = digit;
    end
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

[rtl/core/signed_int_to_decimal_ascii_unit.sv]
// channel   | ports                          | moves
// ----------+--------------------------------+------------------------------------
// in        | in_valid, in_ready, value      | one signed 32-bit integer a request
// out       | out_valid, out_ready,          | one ascii character a request,
//           | char_code, last                | last set on the final one
//
// a number is shifted through the double-dabble chain (one magnitude bit per cycle
// through ten bcd cells), then the chain is drained one digit per cycle while the
// output is not stalled; leading zero digits are dropped from the chain unsent.
// reset is synchronous, active high, and returns control to idle with no output.
// a stall on out_ready holds the drain; a new number is taken as soon as the
// previous one has left the chain, while its last character may still wait.
module signed_int_to_decimal_ascii_unit
  import sidc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [VALUE_W-1:0]  value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAR_W-1:0]   char_code,
  output logic                last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [VALUE_W-1:0]   mag;          // magnitude, shifted out msb first
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [REM_CNT_W-1:0] rem_cnt;      // digits still in the chain
  logic                 lead;         // still inside the leading zeros
  logic                 sign_pend;    // minus sign owed to the output

  logic                 in_take;
  logic                 slot_free;
  logic                 push_sign;
  logic                 push_dig;
  logic                 skip_dig;
  logic [DIG_W-1:0]     top_dig;
  cell_ctrl_t           ctrl;

  logic                 cell_bit [NUM_DIGITS];
  logic [DIG_W-1:0]     cell_dig [NUM_DIGITS];

  assign in_ready  = (state == S_IDLE);
  assign in_take   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign top_dig   = cell_dig[NUM_DIGITS-1];

  // the sign always goes out ahead of any digit
  assign push_sign = sign_pend && slot_free;
  assign skip_dig  = (state == S_EMIT) && !sign_pend && lead &&
                     (top_dig == '0) && (rem_cnt > REM_CNT_W'(1));
  assign push_dig  = (state == S_EMIT) && !sign_pend && slot_free && !skip_dig;

  assign ctrl.clr = in_take;
  assign ctrl.dab = (state == S_CONV);
  assign ctrl.dsh = push_dig || skip_dig;

  // ten bcd cells, cell 0 least significant; bits ripple upward during
  // conversion, whole digits move upward during the drain
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic             b_in;
    logic [DIG_W-1:0] d_in;
    if (i == 0) begin : g_first
      assign b_in = mag[VALUE_W-1];
      assign d_in = '0;
    end else begin : g_rest
      assign b_in = cell_bit[i-1];
      assign d_in = cell_dig[i-1];
    end
    sidc_bcd_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .bit_in  (b_in),
      .bit_out (cell_bit[i]),
      .dig_in  (d_in),
      .dig_out (cell_dig[i])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_take) state_next = S_CONV;
      end
      S_CONV: begin
        if (bit_cnt == BIT_CNT_W'(VALUE_W - 1)) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (push_dig && rem_cnt == REM_CNT_W'(1)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      sign_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (in_take) begin
        sign_pend <= value[VALUE_W-1];
      end else if (push_sign) begin
        sign_pend <= 1'b0;
      end
      if (push_sign || push_dig) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and counters, steered by the control state above
  always_ff @(posedge clk) begin
    if (in_take) begin
      // two's complement negate; the most negative value maps to 2^31 unsigned
      mag     <= value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
      bit_cnt <= '0;
      lead    <= 1'b1;
    end else if (state == S_CONV) begin
      mag     <= {mag[VALUE_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
    end
    if (state == S_CONV) begin
      rem_cnt <= REM_CNT_W'(NUM_DIGITS);
    end else if (ctrl.dsh) begin
      rem_cnt <= rem_cnt - REM_CNT_W'(1);
    end
    if (push_dig) lead <= 1'b0;
    if (push_sign) begin
      char_code <= ASCII_MINUS;
      last      <= 1'b0;
    end else if (push_dig) begin
      char_code <= ASCII_ZERO + CHAR_W'(top_dig);
      last      <= (rem_cnt == REM_CNT_W'(1));
    end
  end

  // a new number starts its conversion right after it is taken
  a_take_conv: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == S_CONV))
    else $error("conversion did not start after input request");

  // the drain never runs with an empty chain
  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (rem_cnt != '0))
    else $error("drain with no digits left");

  // an owed sign is always paid before the number ends
  a_sign_done: assert property (@(posedge clk) disable iff (rst)
    sign_pend |-> (state != S_IDLE))
    else $error("minus sign lost");

  // only a minus or a decimal digit ever leaves
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == ASCII_MINUS ||
                   (char_code >= ASCII_ZERO && char_code <= ASCII_NINE)))
    else $error("bad output character");

endmodule
